/* rtl/tpr_pkg.sv */
// shared types, constants and the tap power table of the tap regulator
`default_nettype none

package tpr_pkg;

  // field widths
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned TAP_W     = 8;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned LIMIT_W   = 5;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // digit-serial multiplier geometry
  localparam int unsigned POW_W     = 12;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MCAND_W   = 24;
  localparam int unsigned MPLIER_W  = 16;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned P_DIGITS  = POW_W / DIGIT_W;
  localparam int unsigned G_DIGITS  = GAIN_W / DIGIT_W;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned RND_SHIFT = 22;

  localparam logic [TAP_W-1:0]  TAP_RESET     = 8'd125;
  localparam logic [STEP_W-1:0] FINE_STEP_MAX = 6'd3;

  // register reset values
  localparam logic [SAMPLE_W-1:0] BAND_TOP_RST    = 12'd2770;
  localparam logic [SAMPLE_W-1:0] BAND_BOTTOM_RST = 12'd2720;
  localparam logic [SAMPLE_W-1:0] FINE_TOP_RST    = 12'd2500;
  localparam logic [SAMPLE_W-1:0] FINE_BOTTOM_RST = 12'd2250;
  localparam logic [TAP_W-1:0]    FINE_LIMIT_RST  = 8'd8;
  localparam logic [GAIN_W-1:0]   GAIN_RAISE_RST  = 16'd131;
  localparam logic [GAIN_W-1:0]   GAIN_LOWER_RST  = 16'd426;
  localparam logic [LIMIT_W-1:0]  STEP_LIMIT_RST  = 5'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_TOP    = 3'd0,
    CFG_BAND_BOTTOM = 3'd1,
    CFG_FINE_TOP    = 3'd2,
    CFG_FINE_BOTTOM = 3'd3,
    CFG_FINE_LIMIT  = 3'd4,
    CFG_GAIN_RAISE  = 3'd5,
    CFG_GAIN_LOWER  = 3'd6,
    CFG_STEP_LIMIT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MK_NONE      = 2'd0,
    MK_PROP      = 2'd1,
    MK_FINE_UP   = 2'd2,
    MK_FINE_DOWN = 2'd3
  } move_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL_P,
    ST_LOAD_G,
    ST_MUL_G,
    ST_ROUND,
    ST_FINISH
  } tpr_state_e;

  typedef struct packed {
    logic in_ready;
    logic lookup;
    logic load_g;
    logic mul_step;
    logic round;
    logic finish;
  } tpr_ctrl_t;

  typedef logic [255:0][POW_W-1:0] pow_tbl_t;

  // floor(64 * t^0.7): largest y with y^10 <= t^7 * 2^60
  function automatic logic [POW_W-1:0] tap_pow_f(input logic [TAP_W-1:0] t);
    logic [127:0] t7;
    logic [127:0] lim;
    logic [127:0] c;
    logic [127:0] c5;
    logic [127:0] c10;
    logic [POW_W-1:0] y;
    t7 = 128'd1;
    for (int i = 0; i < 7; i++) begin
      t7 = t7 * 128'(t);
    end
    lim = t7 << 60;
    y = '0;
    for (int b = POW_W - 1; b >= 0; b--) begin
      c   = 128'(y | (POW_W'(1) << b));
      c5  = c * c * c * c * c;
      c10 = c5 * c5;
      if (c10 <= lim) begin
        y[b] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic pow_tbl_t pow_tbl_f();
    pow_tbl_t tbl;
    for (int t = 0; t < 256; t++) begin
      tbl[t] = tap_pow_f(TAP_W'(t));
    end
    return tbl;
  endfunction

  localparam pow_tbl_t POW_TBL = pow_tbl_f();

endpackage

`default_nettype wire

/* rtl/tpr_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module tpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/tpr_serial_mul.sv */
// digit-serial multiply-accumulate unit, msb digit first
`default_nettype none

module tpr_serial_mul
  import tpr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                load_i,
  input  wire logic                step_i,
  input  wire logic [MCAND_W-1:0]  mcand_i,
  input  wire logic [MPLIER_W-1:0] mplier_i,
  output logic      [ACC_W-1:0]    acc_o
);

  logic [MCAND_W-1:0]  mcand_q;
  logic [MPLIER_W-1:0] mplier_q;
  logic [ACC_W-1:0]    acc_q;
  logic [MCAND_W+DIGIT_W-1:0] part;

  // one small partial product per cycle while step_i is high
  assign part = mcand_q * mplier_q[MPLIER_W-1 -: DIGIT_W];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (step_i) begin
      mplier_q <= {mplier_q[MPLIER_W-DIGIT_W-1:0], DIGIT_W'(0)};
      acc_q    <= {acc_q[ACC_W-DIGIT_W-1:0], DIGIT_W'(0)} + ACC_W'(part);
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/tpr_fsm.sv */
// sequencer of the tap regulator
`default_nettype none

module tpr_fsm
  import tpr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       out_free_i,
  output tpr_ctrl_t       ctrl_o,
  output tpr_state_e      state_o
);

  tpr_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_MUL_P;
        cnt_d   = '0;
      end
      ST_MUL_P: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(P_DIGITS - 1)) begin
          state_d = ST_LOAD_G;
        end
      end
      ST_LOAD_G: begin
        state_d = ST_MUL_G;
        cnt_d   = '0;
      end
      ST_MUL_G: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(G_DIGITS - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:   ctrl_o.in_ready = 1'b1;
      ST_LOOKUP: ctrl_o.lookup   = 1'b1;
      ST_MUL_P:  ctrl_o.mul_step = 1'b1;
      ST_LOAD_G: ctrl_o.load_g   = 1'b1;
      ST_MUL_G:  ctrl_o.mul_step = 1'b1;
      ST_ROUND:  ctrl_o.round    = 1'b1;
      ST_FINISH: ctrl_o.finish   = out_free_i;
      default:   ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

/* rtl/per_channel_tap_regulator.sv */
// top level of the per-channel potentiometer tap regulator
`default_nettype none

// Each transaction carries one 12-bit sample of one multiplexed sensor channel.
// The block looks up that channel's 8-bit tap, forms the error against the
// main band, multiplies error * floor(64 * tap^0.7) * gain in a digit-serial
// unit (4-bit digits, three digits of the tap power then four digits of the
// gain), rounds and clamps the step, and moves the tap either proportionally
// or, at low taps with a small step, by one in the fine band. The tap always
// saturates to TAP_LOW..TAP_HIGH. Exactly one result transaction follows each
// input transaction. One item is processed at a time: after acceptance the
// item passes through the table read, the tap power digits of the serial
// multiplier, the operand reload, the gain digits, rounding and update, and
// only then can the next item be accepted. The next sample is taken while an
// earlier result still waits in the output register; the update of that next
// item then waits until the output register is free. Taps live in a ram of
// CHANNELS entries with one valid flop per entry, so a channel never written
// reads as 125 right after reset and no clearing pass is needed. Configuration
// writes are taken at any cycle and must only be made while the block is idle.

module per_channel_tap_regulator
  import tpr_pkg::*;
#(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned TAP_HIGH = 254,
  parameter int unsigned TAP_LOW  = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [SAMPLE_W-1:0]  sample_i,
  input  wire logic [CHAN_W-1:0]    channel_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CHAN_W-1:0]    out_channel_o,
  output logic      [TAP_W-1:0]     new_tap_o,
  output logic      [STEP_W-1:0]    step_taken_o,
  output logic      [1:0]           move_kind_o
);

  localparam int unsigned AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CX_W = AW + CHAN_W;

  localparam logic signed [TAP_W+1:0] TAP_HI_S = (TAP_W+2)'(TAP_HIGH);
  localparam logic signed [TAP_W+1:0] TAP_LO_S = (TAP_W+2)'(TAP_LOW);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] band_top_q, band_bottom_q, fine_top_q, fine_bottom_q;
  logic [TAP_W-1:0]    fine_limit_q;
  logic [GAIN_W-1:0]   gain_raise_q, gain_lower_q;
  logic [LIMIT_W-1:0]  step_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_top_q    <= BAND_TOP_RST;
      band_bottom_q <= BAND_BOTTOM_RST;
      fine_top_q    <= FINE_TOP_RST;
      fine_bottom_q <= FINE_BOTTOM_RST;
      fine_limit_q  <= FINE_LIMIT_RST;
      gain_raise_q  <= GAIN_RAISE_RST;
      gain_lower_q  <= GAIN_LOWER_RST;
      step_limit_q  <= STEP_LIMIT_RST;
    end else if (cfg_we_i) begin
      // upper bits beyond a register's width are dropped
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BAND_TOP:    band_top_q    <= cfg_data_i[SAMPLE_W-1:0];
        CFG_BAND_BOTTOM: band_bottom_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_FINE_TOP:    fine_top_q    <= cfg_data_i[SAMPLE_W-1:0];
        CFG_FINE_BOTTOM: fine_bottom_q <= cfg_data_i[SAMPLE_W-1:0];
        CFG_FINE_LIMIT:  fine_limit_q  <= cfg_data_i[TAP_W-1:0];
        CFG_GAIN_RAISE:  gain_raise_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_LOWER:  gain_lower_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_STEP_LIMIT:  step_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  tpr_ctrl_t  ctrl;
  tpr_state_e state;
  logic       out_valid_q;
  logic       out_free;
  logic       in_fire;

  assign out_free = !out_valid_q || out_ready_i;

  tpr_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .state_o    (state)
  );

  assign in_ready_o = ctrl.in_ready;
  assign in_fire    = in_valid_i && ctrl.in_ready;

  // ---------------------------------------------------------------------------
  // input capture and tap read
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [AW-1:0]       addr_q;
  logic                in_range_q;
  logic [CX_W-1:0]     chan_ext;
  logic [AW-1:0]       chan_addr;

  // channel widened so that any channel count compares correctly
  assign chan_ext  = {AW'(0), channel_i};
  assign chan_addr = chan_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q   <= sample_i;
      chan_q     <= channel_i;
      addr_q     <= chan_addr;
      in_range_q <= (chan_ext < CX_W'(CHANNELS));
    end
  end

  logic [TAP_W-1:0]    ram_rdata;
  logic [CHANNELS-1:0] tap_vld_q;
  logic                tap_we;
  logic [TAP_W-1:0]    tap_new;

  tpr_ram #(
    .WIDTH (TAP_W),
    .DEPTH (CHANNELS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (addr_q),
    .wdata_i (tap_new),
    .re_i    (in_fire),
    .raddr_i (chan_addr),
    .rdata_o (ram_rdata)
  );

  // a tap never written since reset reads as the reset tap
  logic [TAP_W-1:0] tap_rd;
  assign tap_rd = tap_vld_q[addr_q] ? ram_rdata : TAP_RESET;

  // ---------------------------------------------------------------------------
  // error and multiplier operands
  // ---------------------------------------------------------------------------
  logic                below, above;
  logic [SAMPLE_W-1:0] err;
  logic                below_q, above_q;
  logic [TAP_W-1:0]    tap_q;

  assign below = sample_q < band_bottom_q;
  assign above = sample_q > band_top_q;
  assign err   = below ? (band_bottom_q - sample_q) : (sample_q - band_top_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.lookup) begin
      tap_q   <= tap_rd;
      below_q <= below;
      above_q <= above;
    end
  end

  logic [ACC_W-1:0]    acc;
  logic                mul_load;
  logic [MCAND_W-1:0]  mcand;
  logic [MPLIER_W-1:0] mplier;

  // first pass: err * tap power, second pass: that product * gain
  assign mul_load = ctrl.lookup || ctrl.load_g;
  assign mcand    = ctrl.lookup ? MCAND_W'(err) : acc[MCAND_W-1:0];
  assign mplier   = ctrl.lookup ? {POW_TBL[tap_rd], DIGIT_W'(0)}
                                : (below_q ? gain_raise_q : gain_lower_q);

  tpr_serial_mul u_mul (
    .clk_i    (clk_i),
    .load_i   (mul_load),
    .step_i   (ctrl.mul_step),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .acc_o    (acc)
  );

  // ---------------------------------------------------------------------------
  // rounding (half up) and clamp of the magnitude
  // ---------------------------------------------------------------------------
  localparam int unsigned MAG_W = ACC_W - RND_SHIFT + 1;

  logic [MAG_W-1:0]   mag_full;
  logic [LIMIT_W-1:0] mag_q;

  assign mag_full = MAG_W'(acc[ACC_W-1:RND_SHIFT]) + MAG_W'(acc[RND_SHIFT-1]);

  always_ff @(posedge clk_i) begin
    if (ctrl.round) begin
      mag_q <= (mag_full > MAG_W'(step_limit_q)) ? step_limit_q : mag_full[LIMIT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // step and tap update
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]       last_step_q;
  logic [STEP_W-1:0]       step_new;
  logic                    fine_mode, fine_up, fine_dn;
  logic signed [TAP_W+1:0] tap_sum;
  logic [1:0]              kind;

  always_comb begin
    if (below_q) begin
      step_new = {1'b0, mag_q};
    end else if (above_q) begin
      step_new = STEP_W'(0) - {1'b0, mag_q};
    end else begin
      step_new = last_step_q;
    end
  end

  assign fine_mode = (tap_q < fine_limit_q) && ($signed(step_new) < $signed(FINE_STEP_MAX));
  assign fine_up   = sample_q < fine_bottom_q;
  assign fine_dn   = sample_q > fine_top_q;

  always_comb begin
    tap_sum = $signed({2'b00, tap_q});
    kind    = MK_NONE;
    if (fine_mode) begin
      if (fine_up) begin
        tap_sum = tap_sum + (TAP_W+2)'(1);
        kind    = MK_FINE_UP;
      end else if (fine_dn) begin
        tap_sum = tap_sum - (TAP_W+2)'(1);
        kind    = MK_FINE_DOWN;
      end
    end else if (below_q || above_q) begin
      tap_sum = tap_sum + (TAP_W+2)'($signed(step_new));
      kind    = MK_PROP;
    end
  end

  // saturate, upper bound first
  always_comb begin
    if (tap_sum > TAP_HI_S) begin
      tap_new = TAP_W'(TAP_HIGH);
    end else if (tap_sum < TAP_LO_S) begin
      tap_new = TAP_W'(TAP_LOW);
    end else begin
      tap_new = tap_sum[TAP_W-1:0];
    end
  end

  assign tap_we = ctrl.finish && in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q   <= '0;
      last_step_q <= '0;
    end else if (tap_we) begin
      tap_vld_q[addr_q] <= 1'b1;
      last_step_q       <= step_new;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_channel_o <= chan_q;
      // out-of-range channel leaves the state alone and reports tap zero
      new_tap_o     <= in_range_q ? tap_new : '0;
      step_taken_o  <= in_range_q ? step_new : last_step_q;
      move_kind_o   <= in_range_q ? kind : MK_NONE;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // a reported tap is either the out-of-range marker or inside the tap range
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((new_tap_o == '0 && move_kind_o == MK_NONE) ||
                     (new_tap_o >= TAP_W'(TAP_LOW) && new_tap_o <= TAP_W'(TAP_HIGH))))
    else $error("tap outside saturation range");

  // fine moves only happen with a small step
  a_fine_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (move_kind_o == MK_FINE_UP || move_kind_o == MK_FINE_DOWN)) |->
      ($signed(step_taken_o) < $signed(FINE_STEP_MAX)))
    else $error("fine move with large step");

  // one item in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (!in_ready_o && state == ST_LOOKUP))
    else $error("second transaction accepted while busy");

  // a result is only produced from the update state
  a_finish_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state == ST_FINISH))
    else $error("result produced outside update");
`endif

endmodule

`default_nettype wire

/* dv/tb_per_channel_tap_regulator.sv */
// self-checking testbench of the per-channel potentiometer tap regulator
`timescale 1ns / 100ps

module tb_per_channel_tap_regulator
  import tpr_pkg::*;
();

  localparam int unsigned CHANNELS = 16;
  localparam int unsigned TAP_HIGH = 254;
  localparam int unsigned TAP_LOW  = 1;

  // settle margin long enough to clear any item still in flight
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASES        = 11;
  localparam int unsigned PHASE_ITEMS   = 95;
  localparam int unsigned IDLE_PCT      = 38;

  typedef struct {
    logic [CHAN_W-1:0]        chan;
    logic [TAP_W-1:0]         tap;
    logic signed [STEP_W-1:0] step;
    move_kind_e               kind;
  } tap_update_t;

  // one row of the directed plan: either a register write or a sample
  typedef struct {
    bit                       is_cfg;
    cfg_idx_e                 idx;
    logic [CFG_DAT_W-1:0]     data;
    logic [SAMPLE_W-1:0]      sample;
    logic [CHAN_W-1:0]        chan;
    bit                       typed;
    logic [TAP_W-1:0]         tap;
    logic signed [STEP_W-1:0] step;
    move_kind_e               kind;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample;
  logic [CHAN_W-1:0]    channel;
  logic                 out_valid;
  logic                 out_ready;
  logic [CHAN_W-1:0]    out_channel;
  logic [TAP_W-1:0]     new_tap;
  logic [STEP_W-1:0]    step_taken;
  logic [1:0]           move_kind;

  per_channel_tap_regulator #(
    .CHANNELS (CHANNELS),
    .TAP_HIGH (TAP_HIGH),
    .TAP_LOW  (TAP_LOW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample),
    .channel_i     (channel),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_channel_o (out_channel),
    .new_tap_o     (new_tap),
    .step_taken_o  (step_taken),
    .move_kind_o   (move_kind)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the regulator: registers, tap per channel, shared step
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]      m_band_top;
  logic [SAMPLE_W-1:0]      m_band_bottom;
  logic [SAMPLE_W-1:0]      m_fine_top;
  logic [SAMPLE_W-1:0]      m_fine_bottom;
  logic [TAP_W-1:0]         m_fine_limit;
  logic [GAIN_W-1:0]        m_gain_raise;
  logic [GAIN_W-1:0]        m_gain_lower;
  logic [LIMIT_W-1:0]       m_step_limit;
  logic [TAP_W-1:0]         m_taps [CHANNELS];
  logic signed [STEP_W-1:0] m_last_step;

  // floor(64 * t^0.7) for every tap, filled once at time zero
  logic [POW_W-1:0]         tap_pow_lut [256];

  tap_update_t              pending_updates [$];
  tap_update_t              exp_upd;
  int unsigned              n_fail;
  bit                       no_gaps;
  bit                       pressure_arm;
  int unsigned              hold_left;

  // bisection on y^10 <= t^7 * 2^60, which is the exact Q6.6 floor of t^0.7
  function automatic logic [POW_W-1:0] tap_pow_q6(input int t);
    logic [127:0] goal;
    logic [127:0] cand;
    logic [127:0] cand10;
    int           lo;
    int           hi;
    int           mid;
    goal = 128'd1;
    repeat (7) goal = goal * 128'(t);
    goal = goal << 60;
    lo = 0;
    hi = 1 << POW_W;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      cand = 128'(mid);
      cand10 = 128'd1;
      repeat (10) cand10 = cand10 * cand;
      if (cand10 <= goal) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return POW_W'(lo);
  endfunction

  // magnitude of a proportional step: rounded Q.22 product, clamped to the limit
  function automatic int step_mag(input int err, input int tap, input logic [GAIN_W-1:0] gain);
    logic [47:0] prod;
    logic [47:0] mag;
    prod = 48'(err) * 48'(tap_pow_lut[tap]) * 48'(gain);
    mag  = (prod + (48'd1 << 21)) >> 22;
    if (mag > 48'(m_step_limit)) begin
      mag = 48'(m_step_limit);
    end
    return int'(mag);
  endfunction

  task automatic regulate(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] c,
                          output tap_update_t upd);
    int  tap;
    bit  outside;
    upd.chan = c;
    upd.kind = MK_NONE;
    if (c >= CHANNELS) begin
      upd.tap  = '0;
      upd.step = m_last_step;
      return;
    end
    tap = int'(m_taps[c]);
    outside = 1'b1;
    if (s < m_band_bottom) begin
      m_last_step = STEP_W'(step_mag(int'(m_band_bottom) - int'(s), tap, m_gain_raise));
    end else if (s > m_band_top) begin
      m_last_step = STEP_W'(-step_mag(int'(s) - int'(m_band_top), tap, m_gain_lower));
    end else begin
      outside = 1'b0;
    end
    // fine band is tried first, even for samples inside the main band
    if (tap < int'(m_fine_limit) && m_last_step < $signed(FINE_STEP_MAX)) begin
      if (s < m_fine_bottom) begin
        tap++;
        upd.kind = MK_FINE_UP;
      end else if (s > m_fine_top) begin
        tap--;
        upd.kind = MK_FINE_DOWN;
      end
    end else if (outside) begin
      tap += int'(m_last_step);
      upd.kind = MK_PROP;
    end
    if (tap > int'(TAP_HIGH)) begin
      tap = TAP_HIGH;
    end else if (tap < int'(TAP_LOW)) begin
      tap = TAP_LOW;
    end
    m_taps[c] = TAP_W'(tap);
    upd.tap  = TAP_W'(tap);
    upd.step = m_last_step;
  endtask

  function automatic void shadow_write(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] d);
    case (idx)
      CFG_BAND_TOP:    m_band_top    = d[SAMPLE_W-1:0];
      CFG_BAND_BOTTOM: m_band_bottom = d[SAMPLE_W-1:0];
      CFG_FINE_TOP:    m_fine_top    = d[SAMPLE_W-1:0];
      CFG_FINE_BOTTOM: m_fine_bottom = d[SAMPLE_W-1:0];
      CFG_FINE_LIMIT:  m_fine_limit  = d[TAP_W-1:0];
      CFG_GAIN_RAISE:  m_gain_raise  = d[GAIN_W-1:0];
      CFG_GAIN_LOWER:  m_gain_lower  = d[GAIN_W-1:0];
      CFG_STEP_LIMIT:  m_step_limit  = d[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // generous bound, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pressure_arm) begin
        hold_left = HOLD_CYCLES;
        pressure_arm = 1'b0;
      end
      if (hold_left > 0) begin
        // sender keeps offering, so the block fills up and drops in_ready
        hold_left--;
        out_ready <= 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // every result transaction is matched against the oldest pending update
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $error("result transaction with nothing pending: channel %0d", out_channel);
        n_fail++;
      end else begin
        exp_upd = pending_updates.pop_front();
        if (out_channel !== exp_upd.chan) begin
          $error("out_channel: expected %0d, got %0d", exp_upd.chan, out_channel);
          n_fail++;
        end
        if (new_tap !== exp_upd.tap) begin
          $error("new_tap: expected %0d, got %0d", exp_upd.tap, new_tap);
          n_fail++;
        end
        if (step_taken !== exp_upd.step) begin
          $error("step_taken: expected %0d, got %0d", exp_upd.step, $signed(step_taken));
          n_fail++;
        end
        if (move_kind !== exp_upd.kind) begin
          $error("move_kind: expected %0d, got %0d", exp_upd.kind, move_kind);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sample side
  // ---------------------------------------------------------------------------
  task automatic send(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] c,
                      output tap_update_t upd);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= s;
    channel  <= c;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    regulate(s, c, upd);
  endtask

  // wait for every pending update, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    shadow_write(idx, d);
    @(posedge clk_i);
  endtask

  // mode 0 reset values, 1 all zero, 2 all ones, otherwise plausible random
  task automatic configure(input int mode);
    logic [CFG_DAT_W-1:0] val [8];
    int                   top;
    case (mode)
      0: begin
        val[CFG_BAND_TOP]    = CFG_DAT_W'(BAND_TOP_RST);
        val[CFG_BAND_BOTTOM] = CFG_DAT_W'(BAND_BOTTOM_RST);
        val[CFG_FINE_TOP]    = CFG_DAT_W'(FINE_TOP_RST);
        val[CFG_FINE_BOTTOM] = CFG_DAT_W'(FINE_BOTTOM_RST);
        val[CFG_FINE_LIMIT]  = CFG_DAT_W'(FINE_LIMIT_RST);
        val[CFG_GAIN_RAISE]  = CFG_DAT_W'(GAIN_RAISE_RST);
        val[CFG_GAIN_LOWER]  = CFG_DAT_W'(GAIN_LOWER_RST);
        val[CFG_STEP_LIMIT]  = CFG_DAT_W'(STEP_LIMIT_RST);
      end
      1: foreach (val[i]) val[i] = '0;
      2: foreach (val[i]) val[i] = '1;
      default: begin
        val[CFG_BAND_BOTTOM] = CFG_DAT_W'($urandom_range(1500, 3000));
        top = int'(val[CFG_BAND_BOTTOM]) + int'($urandom_range(200));
        val[CFG_BAND_TOP]    = CFG_DAT_W'(top);
        val[CFG_FINE_BOTTOM] = CFG_DAT_W'($urandom_range(1000, 2600));
        top = int'(val[CFG_FINE_BOTTOM]) + int'($urandom_range(400));
        val[CFG_FINE_TOP]    = CFG_DAT_W'(top);
        val[CFG_FINE_LIMIT]  = CFG_DAT_W'($urandom_range(255));
        val[CFG_GAIN_RAISE]  = CFG_DAT_W'($urandom_range(1500));
        val[CFG_GAIN_LOWER]  = CFG_DAT_W'($urandom_range(1500));
        val[CFG_STEP_LIMIT]  = CFG_DAT_W'($urandom_range(31));
        // some registers get raw 16-bit values: inverted bands, dropped upper bits
        foreach (val[i]) begin
          if ($urandom_range(3) == 0) val[i] = CFG_DAT_W'($urandom);
        end
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), val[i]);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] near(input logic [SAMPLE_W-1:0] edge_val);
    int v;
    v = int'(edge_val) + int'($urandom_range(80)) - 40;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // samples crowd around the band and fine edges, with uniform and extreme ones mixed in
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return SAMPLE_W'($urandom);
    if (sel < 52) return near(m_band_bottom);
    if (sel < 74) return near(m_band_top);
    if (sel < 81) return near(m_fine_bottom);
    if (sel < 88) return near(m_fine_top);
    return ($urandom_range(1) == 0) ? '0 : '1;
  endfunction

  function automatic plan_row_t p_item(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] c);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = CFG_BAND_TOP;
    r.data   = '0;
    r.sample = s;
    r.chan   = c;
    r.typed  = 1'b0;
    r.tap    = '0;
    r.step   = '0;
    r.kind   = MK_NONE;
    return r;
  endfunction

  function automatic plan_row_t p_check(input logic [SAMPLE_W-1:0] s,
                                        input logic [CHAN_W-1:0] c,
                                        input logic [TAP_W-1:0] tap,
                                        input logic signed [STEP_W-1:0] step,
                                        input move_kind_e kind);
    plan_row_t r;
    r       = p_item(s, c);
    r.typed = 1'b1;
    r.tap   = tap;
    r.step  = step;
    r.kind  = kind;
    return r;
  endfunction

  function automatic plan_row_t p_cfg(input cfg_idx_e idx, input logic [CFG_DAT_W-1:0] d);
    plan_row_t r;
    r        = p_item('0, '0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = d;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan [$];
    plan_row_t   row;
    tap_update_t upd;
    tap_update_t typed_upd;
    bit          cfg_open;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    sample       = '0;
    channel      = '0;
    n_fail       = 0;
    no_gaps      = 1'b0;
    pressure_arm = 1'b0;
    cfg_open     = 1'b0;

    for (int t = 0; t < 256; t++) tap_pow_lut[t] = tap_pow_q6(t);

    m_band_top    = BAND_TOP_RST;
    m_band_bottom = BAND_BOTTOM_RST;
    m_fine_top    = FINE_TOP_RST;
    m_fine_bottom = FINE_BOTTOM_RST;
    m_fine_limit  = FINE_LIMIT_RST;
    m_gain_raise  = GAIN_RAISE_RST;
    m_gain_lower  = GAIN_LOWER_RST;
    m_step_limit  = STEP_LIMIT_RST;
    foreach (m_taps[i]) m_taps[i] = TAP_RESET;
    m_last_step = '0;

    // after reset: inside the band nothing moves
    plan.push_back(p_check(12'd2745, 4'd0, 8'd125, 6'sd0, MK_NONE));
    // extreme samples give the clamped step both ways
    plan.push_back(p_check(12'd0, 4'd1, 8'd145, 6'sd20, MK_PROP));
    plan.push_back(p_check(12'd4095, 4'd2, 8'd105, -6'sd20, MK_PROP));
    // sample equal to band bottom is inside: old step kept
    plan.push_back(p_check(12'd2720, 4'd3, 8'd125, -6'sd20, MK_NONE));
    plan.push_back(p_item(12'd2771, 4'd3));
    // saturation at the top tap
    repeat (6) plan.push_back(p_item(12'd0, 4'd4));
    plan.push_back(p_check(12'd0, 4'd4, 8'd254, 6'sd20, MK_PROP));
    // fine band at every tap
    plan.push_back(p_cfg(CFG_FINE_LIMIT, 16'd255));
    plan.push_back(p_check(12'd4095, 4'd5, 8'd124, -6'sd20, MK_FINE_DOWN));
    plan.push_back(p_item(12'd0, 4'd5));
    plan.push_back(p_item(12'd2300, 4'd5));
    // saturation at the bottom tap with the widest step
    plan.push_back(p_cfg(CFG_FINE_LIMIT, 16'd0));
    plan.push_back(p_cfg(CFG_STEP_LIMIT, 16'd31));
    plan.push_back(p_cfg(CFG_GAIN_LOWER, 16'hffff));
    repeat (4) plan.push_back(p_item(12'd4095, 4'd6));
    plan.push_back(p_check(12'd4095, 4'd6, 8'd1, -6'sd31, MK_PROP));
    // zero step limit still counts as a proportional move
    plan.push_back(p_cfg(CFG_STEP_LIMIT, 16'd0));
    plan.push_back(p_check(12'd0, 4'd7, 8'd125, 6'sd0, MK_PROP));
    // inverted band and inverted fine band: the lower tests win
    plan.push_back(p_cfg(CFG_BAND_BOTTOM, 16'd3000));
    plan.push_back(p_cfg(CFG_BAND_TOP, 16'd1000));
    plan.push_back(p_cfg(CFG_FINE_BOTTOM, 16'd3000));
    plan.push_back(p_cfg(CFG_FINE_TOP, 16'd1000));
    plan.push_back(p_cfg(CFG_FINE_LIMIT, 16'd255));
    plan.push_back(p_cfg(CFG_STEP_LIMIT, 16'd2));
    plan.push_back(p_cfg(CFG_GAIN_RAISE, 16'hffff));
    plan.push_back(p_check(12'd2000, 4'd8, 8'd126, 6'sd2, MK_FINE_UP));
    plan.push_back(p_item(12'd4095, 4'd8));
    plan.push_back(p_item(12'd1500, 4'd15));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (!cfg_open) begin
          drain();
          cfg_open = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          @(posedge clk_i);
          cfg_open = 1'b0;
        end
        send(row.sample, row.chan, upd);
        if (row.typed) begin
          typed_upd.chan = row.chan;
          typed_upd.tap  = row.tap;
          typed_upd.step = row.step;
          typed_upd.kind = row.kind;
          pending_updates.push_back(typed_upd);
        end else begin
          pending_updates.push_back(upd);
        end
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure(ph);
      no_gaps = (ph == 3);
      if (ph == 4) pressure_arm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(pick_sample(), CHAN_W'($urandom), upd);
        pending_updates.push_back(upd);
      end
    end

    drain();
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
